// ===== rtl/refcounted_handle_table_core_macros.svh =====
// assertion macros for the handle table checker
`ifndef REFCOUNTED_HANDLE_TABLE_CORE_MACROS_SVH
`define REFCOUNTED_HANDLE_TABLE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RHT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle table check failed");

// next-cycle implication, sampled on clk, off while in reset
`define RHT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle table check failed");

`endif

// ===== rtl/rht_pkg.sv =====
// shared types and constants for the reference-counted handle table
`timescale 1ns / 1ps
`default_nettype none

package rht_pkg;

    // table geometry
    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LIVE_W   = $clog2(CAPACITY + 1);
    localparam int REFS_W   = 16;

    // command queue between front and back
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [SLOT_W-1:0]   slot_idx_t;
    typedef logic [LIVE_W-1:0]   live_t;
    typedef logic [REFS_W-1:0]   refs_t;

    localparam refs_t REFS_MAX = {REFS_W{1'b1}};

    // command codes on the request channel
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_DROP = 1'b1;

    // result status codes
    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_SHARED   = 3'd1;
    localparam logic [2:0] ST_NULL     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DECR     = 3'd4;
    localparam logic [2:0] ST_RELEASED = 3'd5;
    localparam logic [2:0] ST_NOTFOUND = 3'd6;

    // classified operation
    typedef enum logic [1:0] {
        OP_ADD,
        OP_DROP,
        OP_NULL
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        key_t     key;
        logic     has_release;
    } op_t;

    // front to queue push side
    typedef struct packed {
        logic valid;
        op_t  op;
    } q_push_t;

    // queue to back pop side
    typedef struct packed {
        logic not_empty;
        op_t  head;
    } q_head_t;

    // per-slot count and release flag
    typedef struct packed {
        refs_t refs;
        logic  release_flag;
    } slot_ent_t;

    typedef enum logic {
        S_LOOK,
        S_UPDATE
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/rht_front.sv =====
// front end: takes request beats and classifies them into operations
`timescale 1ns / 1ps
`default_nettype none

module rht_front (
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire logic            command,
    input  wire logic [31:0]     key,
    input  wire logic            has_release,
    input  wire logic            q_full,
    output rht_pkg::q_push_t     push
);

    rht_pkg::key_t key_used;

    // key taken to table width
    assign key_used = rht_pkg::key_t'(key);

    // hold off while the queue has no room
    assign req_stall = q_full;

    // classify the beat
    always_comb
    begin
        push.valid          = req_valid && !q_full;
        push.op.key         = key_used;
        push.op.has_release = has_release;
        if (key_used == '0)
        begin
            push.op.kind = rht_pkg::OP_NULL;
        end
        else if (command == rht_pkg::CMD_DROP)
        begin
            push.op.kind = rht_pkg::OP_DROP;
        end
        else
        begin
            push.op.kind = rht_pkg::OP_ADD;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rht_queue.sv =====
// short operation queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module rht_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rht_pkg::q_push_t push,
    output logic                  q_full,
    input  wire logic             pop,
    output rht_pkg::q_head_t      head
);

    rht_pkg::op_t                  entry_reg [rht_pkg::Q_DEPTH];
    logic [rht_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rht_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rht_pkg::Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                          do_push, do_pop;

    localparam logic [rht_pkg::Q_PTR_W-1:0] PTR_LAST =
        rht_pkg::Q_PTR_W'(rht_pkg::Q_DEPTH - 1);
    localparam logic [rht_pkg::Q_CNT_W-1:0] CNT_FULL =
        rht_pkg::Q_CNT_W'(rht_pkg::Q_DEPTH);

    assign q_full         = (cnt_reg == CNT_FULL);
    assign head.not_empty = (cnt_reg != '0);
    assign head.head      = entry_reg[rd_ptr_reg];
    assign do_push        = push.valid && !q_full;
    assign do_pop         = pop && head.not_empty;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.op;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rht_back.sv =====
// back end: key lookup, count read-modify-write and result register
`timescale 1ns / 1ps
`default_nettype none

module rht_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rht_pkg::q_head_t head,
    output logic                  pop,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output logic [2:0]            status,
    output logic [3:0]            slot,
    output logic                  release_request,
    output logic [15:0]           ref_count,
    output logic [4:0]            live_entries
);

    rht_pkg::back_state_t   state_reg, state_next;
    rht_pkg::op_t           op_reg;
    rht_pkg::slot_idx_t     pick_idx_reg;
    logic                   pick_found_reg;
    logic                   pick_empty_reg;
    logic                   valid_reg [rht_pkg::CAPACITY];
    rht_pkg::key_t          key_reg   [rht_pkg::CAPACITY];
    rht_pkg::live_t         live_reg, live_next;
    rht_pkg::slot_ent_t     ent_mem   [rht_pkg::CAPACITY];
    rht_pkg::slot_ent_t     ent_rd_reg;

    logic                   out_valid_reg;
    logic [2:0]             out_status_reg;
    logic [3:0]             out_slot_reg;
    logic                   out_rel_reg;
    logic [15:0]            out_refs_reg;

    rht_pkg::slot_idx_t     pick_idx;
    logic                   pick_found;
    logic                   pick_empty;
    logic                   commit;

    logic [2:0]             res_status;
    logic                   res_slot_hit;
    logic                   res_rel;
    rht_pkg::refs_t         res_refs;
    logic                   mem_we;
    rht_pkg::slot_ent_t     mem_wdata;
    logic                   slot_fill;
    logic                   slot_clear;

    // priority pick over all slots for the queue head
    always_comb
    begin
        pick_found = 1'b0;
        pick_empty = 1'b0;
        pick_idx   = '0;
        for (int i = 0; i < rht_pkg::CAPACITY; i++)
        begin
            if (!pick_found)
            begin
                if (head.head.kind == rht_pkg::OP_ADD && !valid_reg[i])
                begin
                    pick_found = 1'b1;
                    pick_empty = 1'b1;
                    pick_idx   = rht_pkg::slot_idx_t'(i);
                end
                else if (valid_reg[i] && key_reg[i] == head.head.key)
                begin
                    pick_found = 1'b1;
                    pick_idx   = rht_pkg::slot_idx_t'(i);
                end
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            rht_pkg::S_LOOK:
            begin
                if (head.not_empty)
                begin
                    pop        = 1'b1;
                    state_next = rht_pkg::S_UPDATE;
                end
            end
            rht_pkg::S_UPDATE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    commit     = 1'b1;
                    state_next = rht_pkg::S_LOOK;
                end
            end
            default:
            begin
                state_next = rht_pkg::S_LOOK;
            end
        endcase
    end

    // result and slot update for the held operation
    always_comb
    begin
        res_status   = rht_pkg::ST_NULL;
        res_slot_hit = 1'b0;
        res_rel      = 1'b0;
        res_refs     = '0;
        mem_we       = 1'b0;
        mem_wdata    = ent_rd_reg;
        slot_fill    = 1'b0;
        slot_clear   = 1'b0;
        case (op_reg.kind)
            rht_pkg::OP_ADD:
            begin
                if (!pick_found_reg)
                begin
                    res_status = rht_pkg::ST_FULL;
                    res_rel    = op_reg.has_release;
                end
                else if (pick_empty_reg)
                begin
                    res_status             = rht_pkg::ST_ADDED;
                    res_slot_hit           = 1'b1;
                    res_refs               = rht_pkg::refs_t'(1);
                    mem_we                 = 1'b1;
                    mem_wdata.refs         = rht_pkg::refs_t'(1);
                    mem_wdata.release_flag = op_reg.has_release;
                    slot_fill              = 1'b1;
                end
                else
                begin
                    res_status   = rht_pkg::ST_SHARED;
                    res_slot_hit = 1'b1;
                    res_refs     = (ent_rd_reg.refs == rht_pkg::REFS_MAX) ?
                                   ent_rd_reg.refs : ent_rd_reg.refs + 1'b1;
                    mem_we         = 1'b1;
                    mem_wdata.refs = res_refs;
                end
            end
            rht_pkg::OP_DROP:
            begin
                if (!pick_found_reg)
                begin
                    res_status = rht_pkg::ST_NOTFOUND;
                end
                else if (ent_rd_reg.refs <= rht_pkg::refs_t'(1))
                begin
                    res_status   = rht_pkg::ST_RELEASED;
                    res_slot_hit = 1'b1;
                    res_rel      = ent_rd_reg.release_flag;
                    slot_clear   = 1'b1;
                end
                else
                begin
                    res_status     = rht_pkg::ST_DECR;
                    res_slot_hit   = 1'b1;
                    res_refs       = ent_rd_reg.refs - 1'b1;
                    mem_we         = 1'b1;
                    mem_wdata.refs = res_refs;
                end
            end
            default:
            begin
                res_status = rht_pkg::ST_NULL;
            end
        endcase
    end

    // live entry count
    always_comb
    begin
        live_next = live_reg;
        if (commit && slot_fill)
        begin
            live_next = live_reg + 1'b1;
        end
        else if (commit && slot_clear && live_reg != '0)
        begin
            live_next = live_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rht_pkg::S_LOOK;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < rht_pkg::CAPACITY; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit && slot_fill)
            begin
                valid_reg[pick_idx_reg] <= 1'b1;
            end
            else if (commit && slot_clear)
            begin
                valid_reg[pick_idx_reg] <= 1'b0;
            end
        end
    end

    // lookup capture and key store
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg         <= head.head;
            pick_idx_reg   <= pick_idx;
            pick_found_reg <= pick_found;
            pick_empty_reg <= pick_empty;
        end
        if (commit && slot_fill)
        begin
            key_reg[pick_idx_reg] <= op_reg.key;
        end
    end

    // count and flag memory
    always_ff @(posedge clk)
    begin
        if (commit && mem_we)
        begin
            ent_mem[pick_idx_reg] <= mem_wdata;
        end
        if (pop)
        begin
            ent_rd_reg <= ent_mem[pick_idx];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot_hit ? 4'(pick_idx_reg) : 4'd0;
            out_rel_reg    <= res_rel;
            out_refs_reg   <= 16'(res_refs);
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign slot            = out_slot_reg;
    assign release_request = out_rel_reg;
    assign ref_count       = out_refs_reg;
    assign live_entries    = 5'(live_reg);

endmodule

`default_nettype wire

// ===== rtl/refcounted_handle_table_core.sv =====
// top level of the reference-counted handle table
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------------
//  req     | req_valid | req_stall | command, key, has_release
//  rsp     | rsp_valid | rsp_stall | status, slot, release_request, ref_count,
//          |           |           | live_entries
//
// in the back end, S_LOOK does the parallel key compare and priority pick with the
// count memory read, and S_UPDATE does the count update
// items are processed one at a time; a two-entry queue holds beats behind it
// reset clears the slot valid bits, the live count and the queue; no sweep
// a stalled result holds the update cycle until the result beat is taken
`timescale 1ns / 1ps
`default_nettype none

module refcounted_handle_table_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic        command,
    input  wire logic [31:0] key,
    input  wire logic        has_release,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [2:0]       status,
    output logic [3:0]       slot,
    output logic             release_request,
    output logic [15:0]      ref_count,
    output logic [4:0]       live_entries
);

    rht_pkg::q_push_t push;
    rht_pkg::q_head_t head;
    logic             q_full;
    logic             pop;

    // request classification
    rht_front u_front (
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .command     (command),
        .key         (key),
        .has_release (has_release),
        .q_full      (q_full),
        .push        (push)
    );

    // operation queue
    rht_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .q_full (q_full),
        .pop    (pop),
        .head   (head)
    );

    // table and result
    rht_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .slot            (slot),
        .release_request (release_request),
        .ref_count       (ref_count),
        .live_entries    (live_entries)
    );

endmodule

`default_nettype wire

// ===== rtl/rht_checker.sv =====
// port-level checks for the handle table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "refcounted_handle_table_core_macros.svh"

module rht_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_stall,
    input wire logic [2:0]  status,
    input wire logic [3:0]  slot,
    input wire logic        release_request,
    input wire logic [15:0] ref_count,
    input wire logic [4:0]  live_entries
);

    logic full_beat;
    logic no_slot_beat;
    logic added_beat;
    logic released_beat;

    // result beats by status
    assign full_beat     = rsp_valid && status == rht_pkg::ST_FULL;
    assign no_slot_beat  = rsp_valid && (status == rht_pkg::ST_NULL ||
                                         status == rht_pkg::ST_FULL ||
                                         status == rht_pkg::ST_NOTFOUND);
    assign added_beat    = rsp_valid && status == rht_pkg::ST_ADDED;
    assign released_beat = rsp_valid && status == rht_pkg::ST_RELEASED;

    // a stalled result beat stays up
    `RHT_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

    // full only when every slot is occupied
    `RHT_ASSERT_IMP(a_full_live, full_beat, live_entries == 5'(rht_pkg::CAPACITY))

    // results that touch no slot report slot and count zero
    `RHT_ASSERT_IMP(a_no_slot, no_slot_beat, slot == 4'd0 && ref_count == 16'd0)

    // a fresh entry starts at one reference with no release
    `RHT_ASSERT_IMP(a_added, added_beat, ref_count == 16'd1 && !release_request)

    // a cleared slot reports count zero
    `RHT_ASSERT_IMP(a_released, released_beat, ref_count == 16'd0)

endmodule

bind refcounted_handle_table_core rht_checker u_checker (.*);

`default_nettype wire

// ===== sim/refcounted_handle_table_core_tb.sv =====
// self-checking testbench for the reference-counted handle table core
`timescale 1ns / 1ps

module refcounted_handle_table_core_tb;

    localparam int          POOL_N      = 24;
    localparam int          RANDOM_CMDS = 870;
    localparam int          SHARE_ADDS  = 40;
    localparam int          DRAIN_WAIT  = 20;
    localparam int unsigned CYCLE_LIMIT = 1500000;

    typedef enum int {
        IDLE_NONE,
        IDLE_BOTH,
        IDLE_SEND,
        IDLE_RECV
    } idle_style_t;

    // one request beat plus the idle cycles drawn for it
    typedef struct {
        logic            command;
        rht_pkg::key_t   key;
        logic            has_release;
        int unsigned     send_gap;
        int unsigned     recv_gap;
    } tbl_cmd_t;

    // one predicted result beat
    typedef struct {
        logic [2:0]         status;
        rht_pkg::slot_idx_t slot;
        logic               release_request;
        rht_pkg::refs_t     ref_count;
        rht_pkg::live_t     live_entries;
        int unsigned        recv_gap;
    } tbl_outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        command = rht_pkg::CMD_ADD;
    logic [31:0] key = '0;
    logic        has_release = 1'b0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic        release_request;
    logic [15:0] ref_count;
    logic [4:0]  live_entries;

    // shadow copy of the table
    rht_pkg::key_t  tbl_key  [rht_pkg::CAPACITY];
    rht_pkg::refs_t tbl_refs [rht_pkg::CAPACITY];
    logic           tbl_flag [rht_pkg::CAPACITY];
    rht_pkg::live_t tbl_live;

    tbl_cmd_t     cmd_backlog[$];
    tbl_outcome_t predicted_outcomes[$];

    int          mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned cur_recv_gap = 0;
    tbl_cmd_t     next_cmd;
    tbl_outcome_t new_outcome;
    tbl_outcome_t want;

    refcounted_handle_table_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .command         (command),
        .key             (key),
        .has_release     (has_release),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .slot            (slot),
        .release_request (release_request),
        .ref_count       (ref_count),
        .live_entries    (live_entries)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // apply one command to the shadow table and return its result
    function automatic tbl_outcome_t apply_table_cmd(input logic cmd,
                                                     input rht_pkg::key_t k,
                                                     input logic rel);
        tbl_outcome_t o;
        bit           done;
        o.status          = rht_pkg::ST_NOTFOUND;
        o.slot            = '0;
        o.release_request = 1'b0;
        o.ref_count       = '0;
        o.recv_gap        = 0;
        done              = 1'b0;
        if (k == '0)
        begin
            o.status = rht_pkg::ST_NULL;
        end
        else if (cmd == rht_pkg::CMD_ADD)
        begin
            // first empty or matching slot wins
            o.status          = rht_pkg::ST_FULL;
            o.release_request = rel;
            for (int i = 0; i < rht_pkg::CAPACITY && !done; i++)
            begin
                if (tbl_key[i] == '0)
                begin
                    tbl_key[i]        = k;
                    tbl_refs[i]       = rht_pkg::refs_t'(1);
                    tbl_flag[i]       = rel;
                    tbl_live          = tbl_live + 1'b1;
                    o.status          = rht_pkg::ST_ADDED;
                    o.slot            = rht_pkg::slot_idx_t'(i);
                    o.release_request = 1'b0;
                    o.ref_count       = rht_pkg::refs_t'(1);
                    done              = 1'b1;
                end
                else if (tbl_key[i] == k)
                begin
                    // count saturates, stored flag is kept
                    if (tbl_refs[i] != rht_pkg::REFS_MAX)
                        tbl_refs[i] = tbl_refs[i] + 1'b1;
                    o.status          = rht_pkg::ST_SHARED;
                    o.slot            = rht_pkg::slot_idx_t'(i);
                    o.release_request = 1'b0;
                    o.ref_count       = tbl_refs[i];
                    done              = 1'b1;
                end
            end
        end
        else
        begin
            for (int i = 0; i < rht_pkg::CAPACITY && !done; i++)
            begin
                if (tbl_key[i] == k)
                begin
                    o.slot = rht_pkg::slot_idx_t'(i);
                    if (tbl_refs[i] <= rht_pkg::refs_t'(1))
                    begin
                        // last reference frees the slot
                        o.status          = rht_pkg::ST_RELEASED;
                        o.release_request = tbl_flag[i];
                        tbl_key[i]        = '0;
                        tbl_refs[i]       = '0;
                        tbl_flag[i]       = 1'b0;
                        if (tbl_live != '0)
                            tbl_live = tbl_live - 1'b1;
                    end
                    else
                    begin
                        tbl_refs[i] = tbl_refs[i] - 1'b1;
                        o.status    = rht_pkg::ST_DECR;
                        o.ref_count = tbl_refs[i];
                    end
                    done = 1'b1;
                end
            end
        end
        o.live_entries = tbl_live;
        return o;
    endfunction

    function automatic int unsigned draw_gap(input idle_style_t style, input bit recv_side);
        int unsigned g;
        g = 0;
        case (style)
            IDLE_BOTH: g = $urandom_range(0, 8);
            IDLE_SEND: g = recv_side ? 0 : $urandom_range(0, 8);
            IDLE_RECV: g = recv_side ? $urandom_range(0, 8) : 0;
            default:   g = 0;
        endcase
        return g;
    endfunction

    function automatic rht_pkg::key_t nonzero_key();
        rht_pkg::key_t k;
        do
            k = rht_pkg::key_t'($urandom);
        while (k == '0);
        return k;
    endfunction

    task automatic push_cmd(input logic cmd, input rht_pkg::key_t k, input logic rel,
                            input idle_style_t style);
        tbl_cmd_t c;
        c.command     = cmd;
        c.key         = k;
        c.has_release = rel;
        c.send_gap    = draw_gap(style, 1'b0);
        c.recv_gap    = draw_gap(style, 1'b1);
        cmd_backlog.push_back(c);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch on %s: got %0h, expected %0h", field, got, exp_val);
        mismatch_cnt++;
    endtask

    // request driver: predicts each accepted beat, then loads the next one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                new_outcome          = apply_table_cmd(command, key, has_release);
                new_outcome.recv_gap = cur_recv_gap;
                predicted_outcomes.push_back(new_outcome);
            end
            // a stalled beat holds its payload
            if (!(req_valid && req_stall))
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    req_valid <= 1'b0;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    next_cmd = cmd_backlog.pop_front();
                    command      <= next_cmd.command;
                    key          <= next_cmd.key;
                    has_release  <= next_cmd.has_release;
                    req_valid    <= 1'b1;
                    cur_recv_gap = next_cmd.recv_gap;
                    send_wait    = next_cmd.send_gap;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each taken beat against the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_outcomes.size() == 0)
                begin
                    report_mismatch("unexpected result status", 32'(status), '0);
                    recv_wait = 0;
                end
                else
                begin
                    want = predicted_outcomes.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (slot !== want.slot)
                        report_mismatch("slot", 32'(slot), 32'(want.slot));
                    if (release_request !== want.release_request)
                        report_mismatch("release_request", 32'(release_request),
                                        32'(want.release_request));
                    if (ref_count !== want.ref_count)
                        report_mismatch("ref_count", 32'(ref_count),
                                        32'(want.ref_count));
                    if (live_entries !== want.live_entries)
                        report_mismatch("live_entries", 32'(live_entries),
                                        32'(want.live_entries));
                    recv_wait = want.recv_gap;
                end
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
            end
            rsp_stall <= (recv_wait > 0);
        end
    end

    // run limit
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        rht_pkg::key_t seed_keys [15];
        rht_pkg::key_t key_pool  [POOL_N];
        rht_pkg::key_t sat_key;
        rht_pkg::key_t k;
        idle_style_t   style;
        int            n_rand;
        int            phase_len;
        int            add_pct;
        int            roll;
        logic          cmd;

        for (int i = 0; i < rht_pkg::CAPACITY; i++)
        begin
            tbl_key[i]  = '0;
            tbl_refs[i] = '0;
            tbl_flag[i] = 1'b0;
        end
        tbl_live = '0;

        seed_keys[0] = 32'h8000_0000;
        for (int i = 1; i < 15; i++)
            seed_keys[i] = nonzero_key();
        sat_key = nonzero_key();
        for (int i = 0; i < POOL_N; i++)
            key_pool[i] = (i < 15) ? seed_keys[i] : nonzero_key();

        // null keys, unknown drop, share and release on one key
        push_cmd(rht_pkg::CMD_ADD,  '0, 1'b1, IDLE_BOTH);
        push_cmd(rht_pkg::CMD_DROP, '0, 1'b1, IDLE_BOTH);
        push_cmd(rht_pkg::CMD_DROP, 32'hFFFF_FFFF, 1'b0, IDLE_BOTH);
        push_cmd(rht_pkg::CMD_ADD,  32'hFFFF_FFFF, 1'b1, IDLE_BOTH);
        push_cmd(rht_pkg::CMD_ADD,  32'hFFFF_FFFF, 1'b0, IDLE_BOTH);
        push_cmd(rht_pkg::CMD_DROP, 32'hFFFF_FFFF, 1'b0, IDLE_BOTH);
        push_cmd(rht_pkg::CMD_DROP, 32'hFFFF_FFFF, 1'b1, IDLE_BOTH);

        // fill the table, then hit it while full
        push_cmd(rht_pkg::CMD_ADD, 32'h0000_0001, 1'b0, IDLE_BOTH);
        for (int i = 0; i < 15; i++)
            push_cmd(rht_pkg::CMD_ADD, seed_keys[i], 1'($urandom_range(0, 1)), IDLE_BOTH);
        push_cmd(rht_pkg::CMD_ADD,  sat_key, 1'b1, IDLE_BOTH);
        push_cmd(rht_pkg::CMD_ADD,  sat_key, 1'b0, IDLE_BOTH);
        push_cmd(rht_pkg::CMD_ADD,  seed_keys[14], 1'b1, IDLE_BOTH);
        push_cmd(rht_pkg::CMD_DROP, 32'h0000_0001, 1'b1, IDLE_BOTH);
        push_cmd(rht_pkg::CMD_ADD,  sat_key, 1'b1, IDLE_BOTH);

        // raise one count back to back with no idling, then step it down
        for (int i = 0; i < SHARE_ADDS; i++)
            push_cmd(rht_pkg::CMD_ADD, sat_key, 1'($urandom_range(0, 1)), IDLE_NONE);
        push_cmd(rht_pkg::CMD_DROP, sat_key, 1'b0, IDLE_BOTH);
        push_cmd(rht_pkg::CMD_DROP, sat_key, 1'b1, IDLE_BOTH);

        // random phases: add-heavy, drop-heavy or mixed, over a small key pool
        n_rand = 0;
        while (n_rand < RANDOM_CMDS)
        begin
            phase_len = $urandom_range(30, 80);
            case ($urandom_range(0, 2))
                0:       add_pct = 80;
                1:       add_pct = 25;
                default: add_pct = 55;
            endcase
            style = idle_style_t'($urandom_range(0, 3));
            for (int j = 0; j < phase_len; j++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    k = '0;
                else if (roll < 12)
                    k = rht_pkg::key_t'($urandom);
                else
                    k = key_pool[$urandom_range(0, POOL_N - 1)];
                cmd = ($urandom_range(0, 99) < add_pct) ? rht_pkg::CMD_ADD
                                                        : rht_pkg::CMD_DROP;
                push_cmd(cmd, k, 1'($urandom_range(0, 1)), style);
                n_rand++;
            end
        end

        // reset
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for every beat to be sent and answered
        while (cmd_backlog.size() != 0 || req_valid || predicted_outcomes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
